// File: design/mouse_look_eye_pose_unit_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef MOUSE_LOOK_EYE_POSE_UNIT_DEFINES_SVH
`define MOUSE_LOOK_EYE_POSE_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MLEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define MLEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define MLEP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mlep_pkg.sv
`timescale 1ns / 1ps

package mlep_pkg;

  localparam int ANGLE_BITS_DEF     = 32;
  localparam int COMPONENT_BITS_DEF = 16;

  // 1 mrad and the pitch limit in 40-bit binary angle units.
  localparam logic [63:0] PIX40 = 64'd87496355;
  localparam logic [63:0] LIM40 = 64'd129494605803;

  localparam int CORDIC_STEPS = 20;
  localparam int CORD_W       = 33;
  localparam int MUL_W        = 33;
  localparam int CNT_W        = 5;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam int EYE_W = 17;
  localparam logic [EYE_W-1:0] IPD_RESET = 17'd64000;

  // Last counter value of each phase.
  localparam logic [CNT_W-1:0] ANG_LAST  = 5'd2;
  localparam logic [CNT_W-1:0] CORD_LAST = 5'(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] QUAT_LAST = 5'd4;
  localparam logic [CNT_W-1:0] TERM_LAST = 5'd6;
  localparam logic [CNT_W-1:0] EYE_LAST  = 5'd3;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ANG  = 6'b000010,
    ST_CORD = 6'b000100,
    ST_QUAT = 6'b001000,
    ST_TERM = 6'b010000,
    ST_EYE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic             load;
    logic             ang;
    logic             cord_load;
    logic             cord_step;
    logic             quat;
    logic             term;
    logic             eye;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic out_block;
  } stat_t;

  function automatic logic [63:0] shift_round(input logic [63:0] v, input int s);
    logic [63:0] r;
    if (s == 0) begin
      r = v;
    end else begin
      r = (v + (64'd1 << (s - 1))) >> s;
    end
    return r;
  endfunction

  // atan(2^-k) with pi/4 at 2^29.
  function automatic logic signed [CORD_W-1:0] atan_val(input logic [CNT_W-1:0] k);
    logic signed [CORD_W-1:0] r;
    case (k)
      5'd0:    r = 33'sd536870912;
      5'd1:    r = 33'sd316933406;
      5'd2:    r = 33'sd167458907;
      5'd3:    r = 33'sd85004756;
      5'd4:    r = 33'sd42667331;
      5'd5:    r = 33'sd21354465;
      5'd6:    r = 33'sd10679838;
      5'd7:    r = 33'sd5340245;
      5'd8:    r = 33'sd2670163;
      5'd9:    r = 33'sd1335087;
      5'd10:   r = 33'sd667544;
      5'd11:   r = 33'sd333772;
      5'd12:   r = 33'sd166886;
      5'd13:   r = 33'sd83443;
      5'd14:   r = 33'sd41722;
      5'd15:   r = 33'sd20861;
      5'd16:   r = 33'sd10430;
      5'd17:   r = 33'sd5215;
      5'd18:   r = 33'sd2608;
      5'd19:   r = 33'sd1304;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/mlep_ifs.sv
`timescale 1ns / 1ps

interface mlep_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic               recenter;
  modport source (output valid, delta_x, delta_y, recenter, input ready);
  modport sink (input valid, delta_x, delta_y, recenter, output ready);
endinterface

interface mlep_out_if #(
  parameter int COMPONENT_BITS = mlep_pkg::COMPONENT_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_BITS-1:0]  orient_x;
  logic signed [COMPONENT_BITS-1:0]  orient_y;
  logic signed [COMPONENT_BITS-1:0]  orient_z;
  logic signed [COMPONENT_BITS-1:0]  orient_w;
  logic signed [mlep_pkg::EYE_W-1:0] eye_pos_x;
  logic signed [mlep_pkg::EYE_W-1:0] eye_pos_y;
  logic signed [mlep_pkg::EYE_W-1:0] eye_pos_z;
  modport source (output valid, orient_x, orient_y, orient_z, orient_w,
                  eye_pos_x, eye_pos_y, eye_pos_z, input ready);
  modport sink (input valid, orient_x, orient_y, orient_z, orient_w,
                eye_pos_x, eye_pos_y, eye_pos_z, output ready);
endinterface

interface mlep_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mlep_pkg::EYE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/mlep_cordic.sv
`timescale 1ns / 1ps

module mlep_cordic #(
  parameter int ANGLE_BITS = mlep_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 step,
  input  logic [mlep_pkg::CNT_W-1:0]           k,
  input  logic [ANGLE_BITS-1:0]                angle,
  output logic signed [mlep_pkg::CORD_W-1:0]   cos_o,
  output logic signed [mlep_pkg::CORD_W-1:0]   sin_o
);

  localparam int CW = mlep_pkg::CORD_W;
  localparam int UP = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
  localparam int DN = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [1:0]           quad_r;

  logic [ANGLE_BITS-1:0]        rnd_sum;
  logic [1:0]                   quad;
  logic signed [ANGLE_BITS-1:0] rem;
  logic signed [ANGLE_BITS-1:0] rem_dn;
  logic signed [CW-1:0]         z_init;
  logic signed [CW-1:0]         ddx, ddy, da;

  // Fold the angle into the quadrant nearest zero.
  always_comb begin
    rnd_sum = angle + EIGHTH;
    quad    = rnd_sum[ANGLE_BITS-1 -: 2];
    rem     = $signed(angle - ({quad, {(ANGLE_BITS - 2){1'b0}}}));
    rem_dn  = rem >>> DN;
    z_init  = CW'(rem_dn) <<< UP;
    ddx     = y_r >>> k;
    ddy     = x_r >>> k;
    da      = mlep_pkg::atan_val(k);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= mlep_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= z_init;
      quad_r <= quad;
    end else if (step) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - ddx;
        y_r <= y_r + ddy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + ddx;
        y_r <= y_r - ddy;
        z_r <= z_r + da;
      end
    end
  end

  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_o = x_r;
        sin_o = y_r;
      end
      2'd1: begin
        cos_o = -y_r;
        sin_o = x_r;
      end
      2'd2: begin
        cos_o = -x_r;
        sin_o = -y_r;
      end
      default: begin
        cos_o = y_r;
        sin_o = -x_r;
      end
    endcase
  end

endmodule

// File: design/mlep_datapath.sv
`timescale 1ns / 1ps

module mlep_datapath #(
  parameter int ANGLE_BITS     = mlep_pkg::ANGLE_BITS_DEF,
  parameter int COMPONENT_BITS = mlep_pkg::COMPONENT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mlep_pkg::cmd_t                     cmd,
  output mlep_pkg::stat_t                    stat,
  input  logic                               cfg_valid,
  input  logic [mlep_pkg::EYE_W-1:0]         cfg_data,
  input  logic signed [15:0]                 in_delta_x,
  input  logic signed [15:0]                 in_delta_y,
  input  logic                               in_recenter,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [COMPONENT_BITS-1:0]   out_orient_x,
  output logic signed [COMPONENT_BITS-1:0]   out_orient_y,
  output logic signed [COMPONENT_BITS-1:0]   out_orient_z,
  output logic signed [COMPONENT_BITS-1:0]   out_orient_w,
  output logic signed [mlep_pkg::EYE_W-1:0]  out_eye_pos_x,
  output logic signed [mlep_pkg::EYE_W-1:0]  out_eye_pos_y,
  output logic signed [mlep_pkg::EYE_W-1:0]  out_eye_pos_z
);

  localparam int AB  = ANGLE_BITS;
  localparam int CB  = COMPONENT_BITS;
  localparam int MW  = mlep_pkg::MUL_W;
  localparam int PW  = 2 * MW;
  localparam int CW  = mlep_pkg::CORD_W;
  localparam int EW  = mlep_pkg::EYE_W;
  localparam int PRW = 44;
  localparam int DW  = ((AB > PRW) ? AB : PRW) + 2;
  localparam int SH  = 61 - CB;
  localparam int TW  = 2 * CB + 2;
  localparam int S2  = 2 * CB - 2;
  localparam int EPW = TW + EW + 1;

  localparam logic [63:0] STEP64 = mlep_pkg::shift_round(mlep_pkg::PIX40, 40 - AB);
  localparam logic [63:0] LIM64  = mlep_pkg::shift_round(mlep_pkg::LIM40, 40 - AB);
  localparam logic signed [MW-1:0] STEP = $signed(STEP64[MW-1:0]);
  localparam logic signed [DW-1:0] LIM  = $signed(LIM64[DW-1:0]);

  localparam logic signed [PW:0]  CRND  = (PW + 1)'(1) <<< (SH - 1);
  localparam logic signed [PW:0]  CHI   = ((PW + 1)'(1) <<< (CB - 1)) - (PW + 1)'(1);
  localparam logic signed [PW:0]  CLO   = -CHI - (PW + 1)'(1);
  localparam logic signed [TW-1:0] HALFX = TW'(1) <<< (S2 - 1);
  localparam logic signed [EPW-1:0] ERND = EPW'(1) <<< (S2 - 1);
  localparam logic signed [EPW-1:0] EHI  = EPW'(65535);
  localparam logic signed [EPW-1:0] ELO  = -EPW'(65536);

  logic signed [15:0]    dx_r, dy_r;
  logic                  rc_r;
  logic [EW-1:0]         ipd_r;
  logic [AB-1:0]         yaw_r, pitch_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [CB-1:0]  q_r [4];
  logic signed [TW-1:0]  tx_r, ty_r, tz_r;
  logic signed [EPW-1:0] eprod_r;
  logic signed [EW-1:0]  ex_r, ey_r;
  logic                  out_valid_r;
  logic signed [CB-1:0]  ox_r, oy_r, oz_r, ow_r;
  logic signed [EW-1:0]  epx_r, epy_r, epz_r;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [CW-1:0]  cy, sy, cp, sp;
  logic [mlep_pkg::CNT_W-1:0] cnt_m1;
  logic [1:0]            qi;
  logic signed [PW:0]    pq;
  logic signed [TW-1:0]  pt;
  logic signed [DW-1:0]  pdiff, pclamp;
  logic signed [TW-1:0]  t_sel;
  logic signed [EW-1:0]  e_rnd;

  function automatic logic signed [CB-1:0] to_comp(input logic signed [PW:0] p);
    logic signed [PW:0] v;
    v = (p + CRND) >>> SH;
    if (v > CHI) begin
      v = CHI;
    end else if (v < CLO) begin
      v = CLO;
    end
    return v[CB-1:0];
  endfunction

  function automatic logic signed [EW-1:0] eye_round(input logic signed [EPW-1:0] p);
    logic signed [EPW-1:0] v;
    v = (p + ERND) >>> S2;
    if (v > EHI) begin
      v = EHI;
    end else if (v < ELO) begin
      v = ELO;
    end
    return v[EW-1:0];
  endfunction

  mlep_cordic #(.ANGLE_BITS(AB)) u_cordic_yaw (
    .clk   (clk),
    .load  (cmd.cord_load),
    .step  (cmd.cord_step),
    .k     (cnt_m1),
    .angle (yaw_r),
    .cos_o (cy),
    .sin_o (sy)
  );

  mlep_cordic #(.ANGLE_BITS(AB)) u_cordic_pitch (
    .clk   (clk),
    .load  (cmd.cord_load),
    .step  (cmd.cord_step),
    .k     (cnt_m1),
    .angle (pitch_r),
    .cos_o (cp),
    .sin_o (sp)
  );

  // Operand selection for the shared multiplier; its product is consumed
  // one count later.
  always_comb begin
    cnt_m1 = cmd.cnt - 5'd1;
    qi     = cnt_m1[1:0];
    mul_a  = '0;
    mul_b  = '0;
    if (cmd.ang) begin
      mul_a = MW'(dx_r);
      mul_b = STEP;
      if (cmd.cnt == 5'd1) begin
        mul_a = MW'(dy_r);
      end
    end else if (cmd.quat) begin
      case (cmd.cnt)
        5'd0: begin
          mul_a = cy;
          mul_b = sp;
        end
        5'd1: begin
          mul_a = sy;
          mul_b = cp;
        end
        5'd2: begin
          mul_a = sy;
          mul_b = sp;
        end
        default: begin
          mul_a = cy;
          mul_b = cp;
        end
      endcase
    end else if (cmd.term) begin
      case (cmd.cnt)
        5'd0: begin
          mul_a = MW'(q_r[1]);
          mul_b = MW'(q_r[1]);
        end
        5'd1: begin
          mul_a = MW'(q_r[2]);
          mul_b = MW'(q_r[2]);
        end
        5'd2: begin
          mul_a = MW'(q_r[3]);
          mul_b = MW'(q_r[2]);
        end
        5'd3: begin
          mul_a = MW'(q_r[0]);
          mul_b = MW'(q_r[1]);
        end
        5'd4: begin
          mul_a = MW'(q_r[0]);
          mul_b = MW'(q_r[2]);
        end
        default: begin
          mul_a = MW'(q_r[3]);
          mul_b = MW'(q_r[1]);
        end
      endcase
    end
    // The z component takes the negated product before rounding.
    pq = (qi == 2'd2) ? -(PW + 1)'(prod_r) : (PW + 1)'(prod_r);
    pt = $signed(prod_r[TW-1:0]);
    pdiff = DW'($signed(pitch_r)) - DW'($signed(prod_r[PRW-1:0]));
    if (pdiff > LIM) begin
      pclamp = LIM;
    end else if (pdiff < -LIM) begin
      pclamp = -LIM;
    end else begin
      pclamp = pdiff;
    end
    case (cmd.cnt)
      5'd0:    t_sel = tx_r;
      5'd1:    t_sel = ty_r;
      default: t_sel = tz_r;
    endcase
    e_rnd = eye_round(eprod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipd_r       <= mlep_pkg::IPD_RESET;
      yaw_r       <= '0;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ipd_r <= cfg_data;
      end
      if (cmd.ang && cmd.cnt == 5'd1) begin
        yaw_r <= rc_r ? '0 : yaw_r - prod_r[AB-1:0];
      end
      if (cmd.ang && cmd.cnt == mlep_pkg::ANG_LAST) begin
        pitch_r <= rc_r ? '0 : pclamp[AB-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= in_delta_x;
      dy_r <= in_delta_y;
      rc_r <= in_recenter;
    end
    if (cmd.ang || cmd.quat || cmd.term) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.quat && cmd.cnt != 5'd0) begin
      q_r[qi] <= to_comp(pq);
    end
    if (cmd.term) begin
      case (cmd.cnt)
        5'd1:    tx_r <= HALFX - pt;
        5'd2:    tx_r <= tx_r - pt;
        5'd3:    ty_r <= pt;
        5'd4:    ty_r <= ty_r + pt;
        5'd5:    tz_r <= pt;
        5'd6:    tz_r <= tz_r - pt;
        default: ;
      endcase
    end
    if (cmd.eye) begin
      if (cmd.cnt != mlep_pkg::EYE_LAST) begin
        eprod_r <= $signed({1'b0, ipd_r}) * t_sel;
      end
      if (cmd.cnt == 5'd1) begin
        ex_r <= e_rnd;
      end
      if (cmd.cnt == 5'd2) begin
        ey_r <= e_rnd;
      end
    end
    if (cmd.out_load) begin
      ox_r  <= q_r[0];
      oy_r  <= q_r[1];
      oz_r  <= q_r[2];
      ow_r  <= q_r[3];
      epx_r <= ex_r;
      epy_r <= ey_r;
      epz_r <= e_rnd;
    end
  end

  assign stat.out_block = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_orient_x   = ox_r;
  assign out_orient_y   = oy_r;
  assign out_orient_z   = oz_r;
  assign out_orient_w   = ow_r;
  assign out_eye_pos_x  = epx_r;
  assign out_eye_pos_y  = epy_r;
  assign out_eye_pos_z  = epz_r;

endmodule

// File: design/mlep_ctrl.sv
`timescale 1ns / 1ps

module mlep_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlep_pkg::stat_t stat,
  output mlep_pkg::cmd_t  cmd
);

  mlep_pkg::state_t state_r, state_nxt;
  logic [mlep_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 5'd1;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    case (state_r)
      mlep_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mlep_pkg::ST_ANG;
        end
      end
      mlep_pkg::ST_ANG: begin
        cmd.ang = 1'b1;
        if (cnt_r == mlep_pkg::ANG_LAST) begin
          cnt_nxt   = '0;
          state_nxt = mlep_pkg::ST_CORD;
        end
      end
      mlep_pkg::ST_CORD: begin
        cmd.cord_load = (cnt_r == 5'd0);
        cmd.cord_step = (cnt_r != 5'd0);
        if (cnt_r == mlep_pkg::CORD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = mlep_pkg::ST_QUAT;
        end
      end
      mlep_pkg::ST_QUAT: begin
        cmd.quat = 1'b1;
        if (cnt_r == mlep_pkg::QUAT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = mlep_pkg::ST_TERM;
        end
      end
      mlep_pkg::ST_TERM: begin
        cmd.term = 1'b1;
        if (cnt_r == mlep_pkg::TERM_LAST) begin
          cnt_nxt   = '0;
          state_nxt = mlep_pkg::ST_EYE;
        end
      end
      mlep_pkg::ST_EYE: begin
        cmd.eye = 1'b1;
        if (cnt_r == mlep_pkg::EYE_LAST) begin
          // Hold the finished result until the output register is free.
          cnt_nxt = cnt_r;
          if (!stat.out_block) begin
            cmd.out_load = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = mlep_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = mlep_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlep_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: design/mouse_look_eye_pose_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// cfg_ch    in         eye_distance_um write, always ready
// in_ch     in         delta_x, delta_y, recenter
// out_ch    out        orient_x/y/z/w, eye_pos_x/y/z
//
// An item passes in order through accept, angle update, CORDIC (yaw and pitch
// lanes side by side, one step a cycle), quaternion, eye term and eye scaling;
// angle update, quaternion and eye term run on the shared multiplier.
// Synchronous active-low reset sets yaw and pitch to zero and ipd to 64000.
// The next item is accepted while a result waits in the output register; a
// second result holds in the last cycle until the first has been taken.
module mouse_look_eye_pose_unit #(
  parameter int ANGLE_BITS     = mlep_pkg::ANGLE_BITS_DEF,
  parameter int COMPONENT_BITS = mlep_pkg::COMPONENT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mlep_cfg_if.sink     cfg_ch,
  mlep_in_if.sink      in_ch,
  mlep_out_if.source   out_ch
);

  mlep_pkg::cmd_t  cmd;
  mlep_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  mlep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlep_datapath #(
    .ANGLE_BITS     (ANGLE_BITS),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .in_delta_x    (in_ch.delta_x),
    .in_delta_y    (in_ch.delta_y),
    .in_recenter   (in_ch.recenter),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_orient_x  (out_ch.orient_x),
    .out_orient_y  (out_ch.orient_y),
    .out_orient_z  (out_ch.orient_z),
    .out_orient_w  (out_ch.orient_w),
    .out_eye_pos_x (out_ch.eye_pos_x),
    .out_eye_pos_y (out_ch.eye_pos_y),
    .out_eye_pos_z (out_ch.eye_pos_z)
  );

endmodule

// File: design/mlep_checker.sv
`timescale 1ns / 1ps
`include "mouse_look_eye_pose_unit_defines.svh"

module mlep_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A pending result stays offered until it is taken.
  `MLEP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  // An accepted item keeps the input side busy in the following cycle.
  `MLEP_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input not busy")
  // A new result appears together with the return to the idle state.
  `MLEP_ASSERT_IMP(a_rose_idle, clk, rst_n, $rose(out_valid), in_ready, "result while busy")
  // Reset empties the output register.
  `MLEP_ASSERT_NXT_ALWAYS(a_reset, clk, !rst_n, !out_valid, "result after reset")

endmodule

bind mouse_look_eye_pose_unit mlep_checker u_mlep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
